### rtl/core/triggered_capture_recorder_assert.svh
// Assertion macros shared by the recorder modules.
// Each use expects i_clk and i_rst_n in scope.
`ifndef TRIGGERED_CAPTURE_RECORDER_ASSERT_SVH
`define TRIGGERED_CAPTURE_RECORDER_ASSERT_SVH

// Same-cycle implication.
`define TCR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcr assertion failed");

// Next-cycle implication.
`define TCR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcr assertion failed");

`endif

### rtl/core/tcr_pkg.sv
package tcr_pkg;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic {
        REG_DURATION = 1'b0,
        REG_INTERVAL = 1'b1
    } t_reg_index;

    localparam logic [31:0] DEFAULT_DURATION = 32'd1500000;
    localparam logic [31:0] DEFAULT_INTERVAL = 32'd23437;
    localparam logic [4:0]  GEAR_NONE        = 5'h1F;

    localparam int DEF_MAX_SAMPLES    = 64;
    localparam int DEF_MAX_RECORDINGS = 8;
    localparam int DEF_VALUE_BITS     = 16;

    // Store commands issued with an accepted request.
    typedef struct packed {
        logic samp_we;
        logic hdr_we;
        logic rd_en;
    } t_cmd;

endpackage

### rtl/core/tcr_ctrl.sv
`include "triggered_capture_recorder_assert.svh"

module tcr_ctrl
    import tcr_pkg::*;
#(
    parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
    parameter int MAX_RECORDINGS = DEF_MAX_RECORDINGS,
    localparam int SLOTS  = MAX_RECORDINGS + 1,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1),
    localparam int AW     = SLOT_W + IDX_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_action,
    input  logic [19:0]         i_step_time,
    input  logic                i_shifting,
    input  logic signed [4:0]   i_gear,
    input  logic [47:0]         i_sample_stamp,
    input  logic [3:0]          i_record_index,
    input  logic [6:0]          i_sample_index,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output t_cmd                o_cmd,
    output logic [AW-1:0]       o_wr_addr,
    output logic [31:0]         o_wr_offset,
    output logic [SLOT_W-1:0]   o_hdr_slot,
    output logic [4:0]          o_hdr_from,
    output logic [4:0]          o_hdr_to,
    output logic [CNT_W-1:0]    o_hdr_cnt,
    output logic [47:0]         o_hdr_stamp,
    output logic [AW-1:0]       o_rd_addr,
    output logic [SLOT_W-1:0]   o_rd_slot,
    output logic                o_rec_ok,
    output logic [3:0]          o_kept
);

    localparam int RSW = ((SLOT_W > 4) ? SLOT_W : 4) + 1;

    logic                r_prev, n_prev;
    logic                r_cap, n_cap;
    logic [31:0]         r_el, n_el;
    logic [31:0]         r_since, n_since;
    logic [4:0]          r_sg, n_sg;
    logic [4:0]          r_lg, n_lg;
    logic [47:0]         r_stamp, n_stamp;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SLOT_W-1:0]   r_oldest, n_oldest;
    logic [SLOT_W-1:0]   r_kept, n_kept;
    logic [31:0]         r_duration, r_interval;

    logic                start, cap_b, store_now, close;
    logic [4:0]          sg_b, lg_b, lg_n;
    logic [47:0]         stamp_b;
    logic [CNT_W-1:0]    cnt_b, cnt_n;
    logic [31:0]         el_b, since_b, el_n, since_n;
    logic [32:0]         el_sum, since_sum;
    logic [SLOT_W:0]     cs_sum, cs_mod;
    logic [SLOT_W-1:0]   cap_slot;
    logic [RSW-1:0]      rs_sum, rs_mod;
    logic                rec_ok;
    t_cmd                cmd;

    // Ring slot positions: running capture fills the slot after the newest kept.
    always_comb begin
        cs_sum   = {1'b0, r_oldest} + {1'b0, r_kept};
        cs_mod   = (cs_sum >= (SLOT_W+1)'(SLOTS)) ? cs_sum - (SLOT_W+1)'(SLOTS) : cs_sum;
        cap_slot = cs_mod[SLOT_W-1:0];
        rs_sum   = RSW'(r_oldest) + RSW'(i_record_index);
        rs_mod   = (rs_sum >= RSW'(SLOTS)) ? rs_sum - RSW'(SLOTS) : rs_sum;
        rec_ok   = RSW'(i_record_index) < RSW'(r_kept);
    end

    // Capture arithmetic for an update request.
    always_comb begin
        start     = i_shifting && !r_prev && !r_cap;
        cap_b     = r_cap || start;
        sg_b      = start ? i_gear : r_sg;
        lg_b      = start ? i_gear : r_lg;
        stamp_b   = start ? i_sample_stamp : r_stamp;
        cnt_b     = start ? '0 : r_cnt;
        el_b      = start ? '0 : r_el;
        since_b   = start ? r_interval : r_since;
        el_sum    = {1'b0, el_b} + {13'b0, i_step_time};
        since_sum = {1'b0, since_b} + {13'b0, i_step_time};
        // saturate both timers
        el_n      = el_sum[32] ? '1 : el_sum[31:0];
        since_n   = since_sum[32] ? '1 : since_sum[31:0];
        lg_n      = (i_gear != sg_b) ? i_gear : lg_b;
        store_now = cap_b && (since_n >= r_interval) && (cnt_b < CNT_W'(MAX_SAMPLES));
        cnt_n     = cnt_b + CNT_W'(store_now);
        close     = cap_b && ((el_n >= r_duration) || (cnt_n == CNT_W'(MAX_SAMPLES)));
    end

    always_comb begin
        n_prev   = r_prev;
        n_cap    = r_cap;
        n_el     = r_el;
        n_since  = r_since;
        n_sg     = r_sg;
        n_lg     = r_lg;
        n_stamp  = r_stamp;
        n_cnt    = r_cnt;
        n_oldest = r_oldest;
        n_kept   = r_kept;
        cmd      = '0;
        if (i_accept) begin
            case (t_action'(i_action))
                ACT_UPDATE: begin
                    n_prev = i_shifting;
                    if (cap_b) begin
                        n_cap       = !close;
                        n_sg        = sg_b;
                        n_lg        = lg_n;
                        n_stamp     = stamp_b;
                        n_el        = el_n;
                        n_since     = store_now ? '0 : since_n;
                        n_cnt       = cnt_n;
                        cmd.samp_we = store_now;
                        // commit a non-empty capture, drop the oldest when full
                        if (close && (cnt_n != '0)) begin
                            cmd.hdr_we = 1'b1;
                            if (r_kept == SLOT_W'(MAX_RECORDINGS)) begin
                                n_oldest = (r_oldest == SLOT_W'(SLOTS - 1)) ?
                                           '0 : r_oldest + 1'b1;
                            end else begin
                                n_kept = r_kept + 1'b1;
                            end
                        end
                    end
                end
                ACT_READ: begin
                    cmd.rd_en = 1'b1;
                end
                ACT_CLEAR: begin
                    n_prev   = 1'b0;
                    n_cap    = 1'b0;
                    n_el     = '0;
                    n_since  = '0;
                    n_sg     = GEAR_NONE;
                    n_lg     = '0;
                    n_stamp  = '0;
                    n_cnt    = '0;
                    n_oldest = '0;
                    n_kept   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b0;
            r_cap      <= 1'b0;
            r_el       <= '0;
            r_since    <= '0;
            r_sg       <= GEAR_NONE;
            r_lg       <= '0;
            r_stamp    <= '0;
            r_cnt      <= '0;
            r_oldest   <= '0;
            r_kept     <= '0;
            r_duration <= DEFAULT_DURATION;
            r_interval <= DEFAULT_INTERVAL;
        end else begin
            r_prev   <= n_prev;
            r_cap    <= n_cap;
            r_el     <= n_el;
            r_since  <= n_since;
            r_sg     <= n_sg;
            r_lg     <= n_lg;
            r_stamp  <= n_stamp;
            r_cnt    <= n_cnt;
            r_oldest <= n_oldest;
            r_kept   <= n_kept;
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_DURATION: r_duration <= (i_cfg_data == '0) ?
                                                DEFAULT_DURATION : i_cfg_data;
                    REG_INTERVAL: r_interval <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_wr_addr   = {cap_slot, cnt_b[IDX_W-1:0]};
    assign o_wr_offset = el_n;
    assign o_hdr_slot  = cap_slot;
    assign o_hdr_from  = sg_b;
    assign o_hdr_to    = lg_n;
    assign o_hdr_cnt   = cnt_n;
    assign o_hdr_stamp = stamp_b;
    assign o_rd_slot   = rec_ok ? rs_mod[SLOT_W-1:0] : '0;
    assign o_rd_addr   = {o_rd_slot, i_sample_index[IDX_W-1:0]};
    assign o_rec_ok    = rec_ok;
    assign o_kept      = 4'(n_kept);

    `TCR_ASSERT_IMP(a_cap_not_full, r_cap, r_cnt < CNT_W'(MAX_SAMPLES))
    `TCR_ASSERT_IMP(a_samp_in_capture, cmd.samp_we, cap_b && !cmd.rd_en)
    `TCR_ASSERT_NXT(a_ring_drops_oldest,
                    cmd.hdr_we && (r_kept == SLOT_W'(MAX_RECORDINGS)),
                    (r_oldest != $past(r_oldest)) && (r_kept == $past(r_kept)))

endmodule

### rtl/core/tcr_store.sv
module tcr_store
    import tcr_pkg::*;
#(
    parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
    parameter int MAX_RECORDINGS = DEF_MAX_RECORDINGS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS,
    localparam int SLOTS  = MAX_RECORDINGS + 1,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1),
    localparam int AW     = SLOT_W + IDX_W
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [4:0][15:0]      i_wr_vals,
    input  logic [31:0]           i_wr_offset,
    input  logic [SLOT_W-1:0]     i_hdr_slot,
    input  logic [4:0]            i_hdr_from,
    input  logic [4:0]            i_hdr_to,
    input  logic [CNT_W-1:0]      i_hdr_cnt,
    input  logic [47:0]           i_hdr_stamp,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [SLOT_W-1:0]     i_rd_slot,
    output logic [4:0]            o_rd_from,
    output logic [4:0]            o_rd_to,
    output logic [CNT_W-1:0]      o_rd_cnt,
    output logic [47:0]           o_rd_stamp,
    output logic [31:0]           o_rd_offset,
    output logic [4:0][15:0]      o_rd_vals
);

    localparam int DEPTH = SLOTS * (2 ** IDX_W);
    localparam int SW    = 5 * VALUE_BITS + 32;
    localparam int HW    = 48 + CNT_W + 10;

    logic [SW-1:0]          samp_mem [0:DEPTH-1];
    logic [HW-1:0]          hdr_mem  [0:SLOTS-1];
    logic [SW-1:0]          r_samp_q;
    logic [HW-1:0]          r_hdr_q;
    logic [SW-1:0]          wr_word;
    logic [VALUE_BITS+15:0] ext;

    // Keep the upper VALUE_BITS of each value.
    always_comb begin
        wr_word = '0;
        for (int k = 0; k < 5; k++) begin
            wr_word[k*VALUE_BITS +: VALUE_BITS] = i_wr_vals[k][15 -: VALUE_BITS];
        end
        wr_word[5*VALUE_BITS +: 32] = i_wr_offset;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.samp_we) begin
            samp_mem[i_wr_addr] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_samp_q <= samp_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_we) begin
            hdr_mem[i_hdr_slot] <= {i_hdr_stamp, i_hdr_cnt, i_hdr_to, i_hdr_from};
        end
        if (i_cmd.rd_en) begin
            r_hdr_q <= hdr_mem[i_rd_slot];
        end
    end

    // Lower bits that were dropped read back as zero.
    always_comb begin
        ext       = '0;
        o_rd_vals = '0;
        for (int k = 0; k < 5; k++) begin
            ext          = {r_samp_q[k*VALUE_BITS +: VALUE_BITS], 16'b0};
            o_rd_vals[k] = ext[VALUE_BITS+15:VALUE_BITS];
        end
    end

    assign o_rd_offset = r_samp_q[5*VALUE_BITS +: 32];
    assign o_rd_from   = r_hdr_q[4:0];
    assign o_rd_to     = r_hdr_q[9:5];
    assign o_rd_cnt    = r_hdr_q[10 +: CNT_W];
    assign o_rd_stamp  = r_hdr_q[10+CNT_W +: 48];

endmodule

### rtl/core/triggered_capture_recorder.sv
// Triggered capture recorder.
// Input channel (i_valid / o_stall): one request per cycle. i_action selects an
// update tick, a read of one stored sample, or a clear of all recordings.
// A rising edge on i_shifting starts a capture; samples are stored every
// sample_interval microseconds until capture_duration or a full record,
// and a non-empty capture joins a ring of MAX_RECORDINGS records.
// Output channel (o_valid / i_stall): exactly one result per request, in order.
// Path: an accepted request goes through the registered read of the sample and
// header memories, then the output register, before o_valid rises.
// Throughput: one request per cycle, sustained while the output is taken.
// Stall: the memory-read stage and the output register hold two requests;
// o_stall rises only when both are full and i_stall is high.
// Configuration: i_cfg_we writes capture_duration (index 0, zero means
// 1500000) or sample_interval (index 1); write only while idle.
// Reset: capture state and the ring are emptied and the registers return to
// their defaults; memory is not cleared, but unwritten data is never output.
`include "triggered_capture_recorder_assert.svh"

module triggered_capture_recorder
    import tcr_pkg::*;
#(
    parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
    parameter int MAX_RECORDINGS = DEF_MAX_RECORDINGS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [19:0]        i_step_time,
    input  logic               i_shifting,
    input  logic signed [4:0]  i_gear,
    input  logic [47:0]        i_sample_stamp,
    input  logic signed [15:0] i_clutch_pressure,
    input  logic signed [15:0] i_engine_speed,
    input  logic signed [15:0] i_torque_request,
    input  logic signed [15:0] i_torque_reduction,
    input  logic signed [15:0] i_clutch_slip,
    input  logic [3:0]         i_record_index,
    input  logic [6:0]         i_sample_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_recording_count,
    output logic               o_found,
    output logic signed [4:0]  o_from_gear,
    output logic signed [4:0]  o_to_gear,
    output logic [47:0]        o_start_stamp,
    output logic [31:0]        o_offset_time,
    output logic [6:0]         o_samples_in_record,
    output logic signed [15:0] o_read_clutch_pressure,
    output logic signed [15:0] o_read_engine_speed,
    output logic signed [15:0] o_read_torque_request,
    output logic signed [15:0] o_read_torque_reduction,
    output logic signed [15:0] o_read_clutch_slip,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int SLOTS  = MAX_RECORDINGS + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int AW     = SLOT_W + IDX_W;

    logic                accept, s2_free, s1_move;
    t_cmd                cmd;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [31:0]         wr_offset;
    logic [SLOT_W-1:0]   hdr_slot, rd_slot;
    logic [4:0]          hdr_from, hdr_to;
    logic [CNT_W-1:0]    hdr_cnt;
    logic [47:0]         hdr_stamp;
    logic                rec_ok;
    logic [3:0]          kept;
    logic [4:0][15:0]    wr_vals;

    logic [4:0]          rd_from, rd_to;
    logic [CNT_W-1:0]    rd_cnt;
    logic [47:0]         rd_stamp;
    logic [31:0]         rd_offset;
    logic [4:0][15:0]    rd_vals;

    // Memory-read stage
    logic                r_s1_valid;
    logic                r_s1_rd;
    logic                r_s1_rec_ok;
    logic [6:0]          r_s1_si;
    logic [3:0]          r_s1_kept;

    // Output register
    logic                r_s2_valid;
    logic [3:0]          r_out_count;
    logic                r_out_found;
    logic [4:0]          r_out_from, r_out_to;
    logic [47:0]         r_out_stamp;
    logic [31:0]         r_out_offset;
    logic [6:0]          r_out_cnt;
    logic [4:0][15:0]    r_out_vals;

    logic [6:0]          cnt_ext;
    logic                hdr_ok, found;

    assign s2_free = !r_s2_valid || !i_stall;
    assign s1_move = r_s1_valid && s2_free;
    assign o_stall = r_s1_valid && !s2_free;
    assign accept  = i_valid && !o_stall;

    assign wr_vals = {i_clutch_slip, i_torque_reduction, i_torque_request,
                      i_engine_speed, i_clutch_pressure};

    tcr_ctrl #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .MAX_RECORDINGS (MAX_RECORDINGS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_step_time    (i_step_time),
        .i_shifting     (i_shifting),
        .i_gear         (i_gear),
        .i_sample_stamp (i_sample_stamp),
        .i_record_index (i_record_index),
        .i_sample_index (i_sample_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (cmd),
        .o_wr_addr      (wr_addr),
        .o_wr_offset    (wr_offset),
        .o_hdr_slot     (hdr_slot),
        .o_hdr_from     (hdr_from),
        .o_hdr_to       (hdr_to),
        .o_hdr_cnt      (hdr_cnt),
        .o_hdr_stamp    (hdr_stamp),
        .o_rd_addr      (rd_addr),
        .o_rd_slot      (rd_slot),
        .o_rec_ok       (rec_ok),
        .o_kept         (kept)
    );

    tcr_store #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .MAX_RECORDINGS (MAX_RECORDINGS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_wr_vals   (wr_vals),
        .i_wr_offset (wr_offset),
        .i_hdr_slot  (hdr_slot),
        .i_hdr_from  (hdr_from),
        .i_hdr_to    (hdr_to),
        .i_hdr_cnt   (hdr_cnt),
        .i_hdr_stamp (hdr_stamp),
        .i_rd_addr   (rd_addr),
        .i_rd_slot   (rd_slot),
        .o_rd_from   (rd_from),
        .o_rd_to     (rd_to),
        .o_rd_cnt    (rd_cnt),
        .o_rd_stamp  (rd_stamp),
        .o_rd_offset (rd_offset),
        .o_rd_vals   (rd_vals)
    );

    always_comb begin
        cnt_ext = 7'(rd_cnt);
        hdr_ok  = r_s1_rd && r_s1_rec_ok;
        found   = hdr_ok && (r_s1_si < cnt_ext) && (r_s1_si < 7'(MAX_SAMPLES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_free) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd     <= cmd.rd_en;
            r_s1_rec_ok <= rec_ok;
            r_s1_si     <= i_sample_index;
            r_s1_kept   <= kept;
        end
        // zero every field a request does not produce
        if (s1_move) begin
            r_out_count  <= r_s1_kept;
            r_out_found  <= found;
            r_out_from   <= hdr_ok ? rd_from : '0;
            r_out_to     <= hdr_ok ? rd_to : '0;
            r_out_stamp  <= hdr_ok ? rd_stamp : '0;
            r_out_cnt    <= hdr_ok ? cnt_ext : '0;
            r_out_offset <= found ? rd_offset : '0;
            r_out_vals   <= found ? rd_vals : '0;
        end
    end

    assign o_valid                 = r_s2_valid;
    assign o_recording_count       = r_out_count;
    assign o_found                 = r_out_found;
    assign o_from_gear             = r_out_from;
    assign o_to_gear               = r_out_to;
    assign o_start_stamp           = r_out_stamp;
    assign o_offset_time           = r_out_offset;
    assign o_samples_in_record     = r_out_cnt;
    assign o_read_clutch_pressure  = r_out_vals[0];
    assign o_read_engine_speed     = r_out_vals[1];
    assign o_read_torque_request   = r_out_vals[2];
    assign o_read_torque_reduction = r_out_vals[3];
    assign o_read_clutch_slip      = r_out_vals[4];

    `TCR_ASSERT_IMP(a_stall_when_full, o_stall, r_s1_valid && r_s2_valid)
    `TCR_ASSERT_NXT(a_accept_fills_s1, accept, r_s1_valid)
    `TCR_ASSERT_NXT(a_move_fills_out, s1_move, r_s2_valid)

endmodule
